@@ hdl/scdm_pkg.sv @@
package scdm_pkg;

  // Delay line and field widths
  localparam int DEF_LINE_DEPTH = 4096;
  localparam int SMP_W          = 24;
  localparam int ACC_W          = 32;
  localparam int DLY_W          = 28;
  localparam int PER_W          = 20;
  localparam int GAIN_W         = 32;
  localparam int CUR_W          = 32;
  localparam int INT_W          = 16;
  localparam int FRAC_SH        = 8;
  localparam int FRAC_W         = 8;
  localparam int CTR_W          = DLY_W + 1 - INT_W;

  // Shared multiplier
  localparam int MUL_A_W = SMP_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Divider for the LFO step
  localparam int QUO_W      = 32;
  localparam int DIV_W      = 20;
  localparam int STEP_CNT_W = 6;
  localparam logic [STEP_CNT_W-1:0] DIV_STEPS_FULL = STEP_CNT_W'(QUO_W);

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [DLY_W-1:0]  RST_MIN_DELAY = DLY_W'(28901376);
  localparam logic [DLY_W-1:0]  RST_MAX_DELAY = DLY_W'(43352064);
  localparam logic [PER_W-1:0]  RST_PERIOD    = PER_W'(176400);
  localparam logic [GAIN_W-1:0] RST_GAIN      = 32'd4294924346;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DELAY  = 2'd0,
    CFG_MAX_DELAY  = 2'd1,
    CFG_LFO_PERIOD = 2'd2,
    CFG_INPUT_GAIN = 2'd3
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLAN,
    ST_STEP_DIV,
    ST_MIX,
    ST_WRITE,
    ST_ADDR,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_RD_D,
    ST_RD_E,
    ST_MUL_R,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [QUO_W-1:0]      dividend;
    logic [DIV_W-1:0]      divisor;
    logic [STEP_CNT_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hdl/scdm_if.sv @@
interface scdm_in_if import scdm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] left_in;
  logic signed [SMP_W-1:0] right_in;
  logic signed [ACC_W-1:0] left_acc;
  logic signed [ACC_W-1:0] right_acc;

  modport source (output valid, output left_in, output right_in, output left_acc,
                  output right_acc, input ready);
  modport sink (input valid, input left_in, input right_in, input left_acc,
                input right_acc, output ready);
endinterface

interface scdm_out_if import scdm_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [ACC_W-1:0] left_out;
  logic signed [ACC_W-1:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface scdm_cfg_if import scdm_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ hdl/stereo_chorus_delay_modulator.sv @@
// Stereo chorus: triangle-LFO modulated delay line with two interpolated taps.
//
// in_ch   request: left_in/right_in (24-bit samples) and left_acc/right_acc.
// out_ch  request: left_out/right_out, the accumulators plus tap one / tap two.
// cfg_ch  register writes by index (min delay, max delay, LFO period, gain);
//         ready out of reset, issue only while the block is idle. A period
//         write restarts the LFO at the minimum delay.
//
// The divider runs only for the LFO step (a load, then one iteration per
// quotient bit); the line depth is a power of two, so both tap offsets reduce
// modulo the depth by their low bits. One multiplier serves the gain and both
// interpolations, and the four line reads go through the one read port of the
// delay RAM. in_ch is ready only in idle, so a request is not taken before
// the previous result has gone to the output register.
//
// The output register decouples the sides: a new request is taken while a
// result waits; a stalled receiver holds the next result in the final state.
// Reset (rst_n, synchronous) holds in_ch and cfg_ch not ready and empties the
// delay line through a fill counter: entries not yet written read as zero.
module stereo_chorus_delay_modulator import scdm_pkg::*; #(
  parameter int LINE_DEPTH = DEF_LINE_DEPTH
) (
  input logic       clk,
  input logic       rst_n,
  scdm_in_if.sink   in_ch,
  scdm_out_if.source out_ch,
  scdm_cfg_if.sink  cfg_ch
);

  localparam int IDX_W = $clog2(LINE_DEPTH);
  localparam int CNT_W = IDX_W + 1;
  localparam int POS_W = IDX_W + 2;
  localparam logic [IDX_W-1:0]        LAST_IDX  = IDX_W'(LINE_DEPTH - 1);
  localparam logic signed [POS_W-1:0] DEPTH_POS = POS_W'(LINE_DEPTH);
  localparam logic [CNT_W-1:0]        DEPTH_CNT = CNT_W'(LINE_DEPTH);

  // Configuration registers
  logic [DLY_W-1:0]  min_dly_r;
  logic [DLY_W-1:0]  max_dly_r;
  logic [PER_W-1:0]  period_r;
  logic [GAIN_W-1:0] gain_r;

  // Block state
  logic [IDX_W-1:0] wr_idx_r;
  logic [PER_W-1:0] phase_r;
  logic [CUR_W-1:0] cur_dly_r;
  logic [CUR_W-1:0] step_r;
  logic [CNT_W-1:0] fill_r;

  state_t state_r, state_nxt;

  // Per-request working registers
  logic signed [SMP_W-1:0]  lin_r, rin_r;
  logic signed [ACC_W-1:0]  lacc_r, racc_r;
  logic                     neg_r;
  logic [IDX_W-1:0]         r_int_r, r_ctr_r;
  logic [IDX_W-1:0]         p1_r, p2_r;
  logic signed [SMP_W-1:0]  t1_r, t1b_r, t2_r, t2b_r;
  logic                     rd_ok_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  lres_r;

  logic                    out_valid_r;
  logic signed [ACC_W-1:0] out_left_r, out_right_r;

  // Handshake helpers
  logic in_take, out_take, load_out;

  // LFO segment planning
  logic [PER_W-1:0]        half;
  logic                    recompute, rising;
  logic signed [PER_W:0]   seg_left;
  logic [DIV_W-1:0]        left_div;
  logic [CUR_W-1:0]        target, diff, mag;
  logic [DLY_W:0]          ctr_sum;
  logic [CTR_W-1:0]        centre;
  logic [INT_W-1:0]        cur_int;
  logic [FRAC_W-1:0]       frac;
  logic [PER_W:0]          phase_inc;

  // Datapath
  logic signed [MUL_A_W-1:0] mix_sum;
  logic signed [SMP_W-1:0]   mix;
  logic                      mul_en;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_A_W-1:0] interp;
  logic signed [SMP_W+1:0]   tap;
  logic signed [POS_W-1:0]   p1_s, p2_s, p1_fix, p2_fix;
  logic [IDX_W-1:0]          p1b, p2b;

  // Memory and divider
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SMP_W-1:0]  ram_rdata;
  logic signed [SMP_W-1:0] rd_val;

  assign in_take  = in_ch.valid && in_ch.ready;
  assign out_take = out_valid_r && out_ch.ready;
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  // LFO: a new step is due at the start of each half period
  assign half      = {1'b0, period_r[PER_W-1:1]};
  assign recompute = (phase_r == '0) || (phase_r == half);
  assign rising    = phase_r < half;
  assign seg_left  = rising ? $signed({1'b0, half}) - $signed({1'b0, phase_r})
                            : $signed({1'b0, period_r}) - $signed({1'b0, phase_r});
  // A degenerate period leaves no samples in the segment: divide by one
  assign left_div  = (seg_left <= 0) ? DIV_W'(1) : seg_left[PER_W-1:0];
  assign target    = rising ? {{(CUR_W-DLY_W){1'b0}}, max_dly_r}
                            : {{(CUR_W-DLY_W){1'b0}}, min_dly_r};
  assign diff      = target - cur_dly_r;
  assign mag       = diff[CUR_W-1] ? (~diff + 1'b1) : diff;

  assign ctr_sum   = {1'b0, min_dly_r} + {1'b0, max_dly_r};
  assign centre    = ctr_sum[DLY_W:INT_W];
  assign cur_int   = cur_dly_r[CUR_W-1:INT_W];
  assign frac      = cur_dly_r[INT_W-1:FRAC_SH];
  assign phase_inc = {1'b0, phase_r} + 1'b1;

  // Average of the pair, arithmetic shift by one
  assign mix_sum = $signed({lin_r[SMP_W-1], lin_r}) + $signed({rin_r[SMP_W-1], rin_r});
  assign mix     = mix_sum[MUL_A_W-1:1];

  // Shared multiplier: gain in the mix step, fraction in the two tap steps
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state_r)
      ST_MIX: begin
        mul_en = 1'b1;
        mul_a  = {mix[SMP_W-1], mix};
        mul_b  = $signed({1'b0, gain_r});
      end
      ST_RD_D: begin
        mul_en = 1'b1;
        mul_a  = $signed({t1b_r[SMP_W-1], t1b_r}) - $signed({t1_r[SMP_W-1], t1_r});
        mul_b  = $signed({{(MUL_B_W-FRAC_W){1'b0}}, frac});
      end
      ST_MUL_R: begin
        mul_en = 1'b1;
        mul_a  = $signed({t2b_r[SMP_W-1], t2b_r}) - $signed({t2_r[SMP_W-1], t2_r});
        mul_b  = $signed({{(MUL_B_W-FRAC_W){1'b0}}, frac});
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // Interpolation term, arithmetic shift by the fraction width
  assign interp = prod_r[FRAC_SH+MUL_A_W-1:FRAC_SH];
  always_comb begin
    if (state_r == ST_RD_E) begin
      tap = $signed({{2{t1_r[SMP_W-1]}}, t1_r}) + $signed({interp[MUL_A_W-1], interp});
    end else begin
      tap = $signed({{2{t2_r[SMP_W-1]}}, t2_r}) + $signed({interp[MUL_A_W-1], interp});
    end
  end

  // Tap positions from the reduced offsets
  assign p1_s   = $signed({2'b00, wr_idx_r}) - $signed({2'b00, r_int_r});
  assign p1_fix = (p1_s < 0) ? p1_s + DEPTH_POS : p1_s;
  assign p2_s   = $signed({2'b00, wr_idx_r}) + $signed({2'b00, r_int_r})
                - $signed({2'b00, r_ctr_r});
  always_comb begin
    if (p2_s < 0) begin
      p2_fix = p2_s + DEPTH_POS;
    end else if (p2_s >= DEPTH_POS) begin
      p2_fix = p2_s - DEPTH_POS;
    end else begin
      p2_fix = p2_s;
    end
  end
  // Tap one leans toward the older entry, tap two toward the newer one
  assign p1b = (p1_r == '0) ? LAST_IDX : p1_r - 1'b1;
  assign p2b = (p2_r == LAST_IDX) ? '0 : p2_r + 1'b1;

  always_comb begin
    case (state_r)
      ST_RD_B: ram_raddr = p1b;
      ST_RD_C: ram_raddr = p2_r;
      ST_RD_D: ram_raddr = p2b;
      default: ram_raddr = p1_r;
    endcase
  end

  // Entries past the fill count were never written since reset: read zero
  assign rd_val = rd_ok_r ? $signed(ram_rdata) : '0;
  assign ram_we = (state_r == ST_WRITE);

  scdm_ram #(
    .WIDTH (SMP_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_idx_r),
    .wdata (prod_r[GAIN_W+SMP_W-1:GAIN_W]),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Divider request: the LFO step at the start of a half period
  always_comb begin
    div_req = '0;
    case (state_r)
      ST_PLAN: begin
        div_req.start    = recompute;
        div_req.dividend = mag;
        div_req.divisor  = left_div;
        div_req.steps    = DIV_STEPS_FULL;
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  scdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = rst_n;
        if (in_take) begin
          state_nxt = ST_PLAN;
        end
      end
      ST_PLAN: begin
        state_nxt = recompute ? ST_STEP_DIV : ST_MIX;
      end
      ST_STEP_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_MIX;
        end
      end
      ST_MIX:   state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = ST_RD_A;
      ST_RD_A:  state_nxt = ST_RD_B;
      ST_RD_B:  state_nxt = ST_RD_C;
      ST_RD_C:  state_nxt = ST_RD_D;
      ST_RD_D:  state_nxt = ST_RD_E;
      ST_RD_E:  state_nxt = ST_MUL_R;
      ST_MUL_R: state_nxt = ST_DONE;
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state, configuration and LFO
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dly_r   <= RST_MIN_DELAY;
      max_dly_r   <= RST_MAX_DELAY;
      period_r    <= RST_PERIOD;
      gain_r      <= RST_GAIN;
      wr_idx_r    <= '0;
      phase_r     <= '0;
      cur_dly_r   <= {{(CUR_W-DLY_W){1'b0}}, RST_MIN_DELAY};
      step_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_take) begin
        out_valid_r <= 1'b0;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end
      if ((state_r == ST_STEP_DIV) && div_rsp.done) begin
        step_r <= neg_r ? (~div_rsp.quotient + 1'b1) : div_rsp.quotient;
      end
      if ((state_r == ST_WRITE) && (fill_r != DEPTH_CNT)) begin
        fill_r <= fill_r + 1'b1;
      end
      // Advance the line and the LFO once the result is handed off
      if (load_out) begin
        cur_dly_r <= cur_dly_r + step_r;
        wr_idx_r  <= (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
        phase_r   <= (phase_inc >= {1'b0, period_r}) ? '0 : phase_inc[PER_W-1:0];
      end
      if (cfg_ch.valid) begin
        case (cfg_reg_t'(cfg_ch.index))
          CFG_MIN_DELAY:  min_dly_r <= cfg_ch.data[DLY_W-1:0];
          CFG_MAX_DELAY:  max_dly_r <= cfg_ch.data[DLY_W-1:0];
          CFG_LFO_PERIOD: begin
            period_r  <= cfg_ch.data[PER_W-1:0];
            phase_r   <= '0;
            cur_dly_r <= {{(CUR_W-DLY_W){1'b0}}, min_dly_r};
          end
          CFG_INPUT_GAIN: gain_r <= cfg_ch.data[GAIN_W-1:0];
          default: begin
            gain_r <= gain_r;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      lin_r  <= in_ch.left_in;
      rin_r  <= in_ch.right_in;
      lacc_r <= in_ch.left_acc;
      racc_r <= in_ch.right_acc;
    end
    if (state_r == ST_PLAN) begin
      neg_r <= diff[CUR_W-1];
    end
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    // Power-of-two depth: keep the low bits of each offset
    if (state_r == ST_WRITE) begin
      r_int_r <= IDX_W'(cur_int);
      r_ctr_r <= IDX_W'(centre);
    end
    if (state_r == ST_ADDR) begin
      p1_r <= p1_fix[IDX_W-1:0];
      p2_r <= p2_fix[IDX_W-1:0];
    end
    rd_ok_r <= ({1'b0, ram_raddr} < fill_r);
    case (state_r)
      ST_RD_B: t1_r  <= rd_val;
      ST_RD_C: t1b_r <= rd_val;
      ST_RD_D: t2_r  <= rd_val;
      ST_RD_E: begin
        t2b_r  <= rd_val;
        lres_r <= lacc_r + ACC_W'(tap);
      end
      default: begin
        t1_r <= t1_r;
      end
    endcase
    if (load_out) begin
      out_left_r  <= lres_r;
      out_right_r <= racc_r + ACC_W'(tap);
    end
  end

  assign cfg_ch.ready     = rst_n;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.left_out  = out_left_r;
  assign out_ch.right_out = out_right_r;

endmodule

@@ hdl/scdm_ram.sv @@
module scdm_ram import scdm_pkg::*; #(
  parameter int WIDTH = SMP_W,
  parameter int DEPTH = DEF_LINE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/scdm_div.sv @@
module scdm_div import scdm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [QUO_W-1:0]      quo_r;
  logic [DIV_W-1:0]      rem_r;
  logic [DIV_W-1:0]      dsr_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DIV_W:0]   shifted;
  logic [DIV_W+1:0] trial;
  logic             fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  assign shifted = {rem_r, quo_r[QUO_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};
  assign fits    = ~trial[DIV_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[QUO_W-2:0], fits};
      rem_r <= fits ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

@@ hdl/scdm_checker.sv @@
module scdm_checker import scdm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ACC_W-1:0] out_left,
  input logic [ACC_W-1:0] out_right
);

  logic [1:0] pend_r;
  logic       in_take, out_take;

  assign in_take  = in_valid && in_ready;
  assign out_take = out_valid && out_ready;

  // Requests taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_take} - {1'b0, out_take};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_left) && $stable(out_right))
    else $error("output payload changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !in_ready)
    else $error("input taken while previous request still in work");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two requests outstanding");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_take |-> pend_r != 2'd0)
    else $error("result delivered without a pending request");

endmodule

bind stereo_chorus_delay_modulator scdm_checker u_scdm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.left_out),
  .out_right (out_ch.right_out)
);
